/* hdl/fmd_pkg.sv */
`default_nettype none

package fmd_pkg;

    localparam int CMD_W     = 16;
    localparam int LIM_W     = 15;
    localparam int LANES     = 4;
    // quarter-lsb mix and its magnitude
    localparam int MIX_W     = CMD_W + 2;
    localparam int MAG_W     = CMD_W + 1;
    // scaled value never exceeds the limit, so the quotient has limit width
    localparam int QUOT_W    = LIM_W;
    localparam int REM_W     = MAG_W + LIM_W;
    localparam int DIV_STEPS = QUOT_W;
    // mix, magnitude, max, product, divider steps, output
    localparam int PIPE_LAT  = 4 + DIV_STEPS + 1;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(2867);

    typedef struct packed {
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
    } t_cmd_word;

    typedef struct packed {
        logic signed [CMD_W-1:0] fin_one;
        logic signed [CMD_W-1:0] fin_two;
        logic signed [CMD_W-1:0] fin_three;
        logic signed [CMD_W-1:0] fin_four;
        logic                    was_scaled;
    } t_fin_word;

    // side data that rides along the divider
    typedef struct packed {
        logic [LANES-1:0]             neg;
        logic                         scaled;
        logic [LIM_W-1:0]             lim;
        logic [LANES-1:0][QUOT_W-1:0] quarter;
    } t_div_side;

endpackage

`default_nettype wire

/* hdl/fin_mixer_desaturate.sv */
// Four-fin mixer with uniform desaturation.
// Input: a command word (roll, pitch, yaw, signed Q2.13) is taken at a clock
// edge where start is high and busy is low. busy is always low: the block is
// a 20-stage pipeline and takes a new word in every cycle.
// Output: o_valid marks the result word for one cycle, once the word has
// passed through every stage. Words come out in the order they went in.
// Config: i_cfg_we writes fin_limit from i_cfg_wdata; change it only while
// no command is in flight.
// Datapath: exact quarter-lsb mix, magnitudes, max search, four 17x15
// multipliers, then a restoring divider that resolves one quotient bit per
// stage for all four fins (15 stages), then select, clamp and sign.
// Throughput is one word per cycle; the divider stage count sets the latency.
// Reset (synchronous, active low) empties the pipeline and sets fin_limit to
// 2867. The receiver cannot stall; results are never held back.
`default_nettype none

module fin_mixer_desaturate
    import fmd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_cmd_word        i_cmd,
    input  wire logic             i_cfg_we,
    input  wire logic [LIM_W-1:0] i_cfg_wdata,
    output logic                  o_valid,
    output t_fin_word             o_fin
);

    logic [LIM_W-1:0] r_fin_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_fin_limit <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // stage 1: mix
    logic                    r_s1_vld;
    logic signed [MIX_W-1:0] r_s1_mix [LANES];
    logic [LIM_W-1:0]        r_s1_lim;
    logic signed [MIX_W-1:0] n_s1_mix [LANES];
    logic signed [MIX_W-1:0] roll_x;
    logic signed [MIX_W-1:0] pitch_x;
    logic signed [MIX_W-1:0] yaw_x;

    always_comb begin
        roll_x      = MIX_W'(i_cmd.roll_cmd);
        pitch_x     = MIX_W'(i_cmd.pitch_cmd);
        yaw_x       = MIX_W'(i_cmd.yaw_cmd);
        n_s1_mix[0] = (yaw_x <<< 1) - roll_x;
        n_s1_mix[1] = -(pitch_x <<< 1) - roll_x;
        n_s1_mix[2] = -(yaw_x <<< 1) - roll_x;
        n_s1_mix[3] = (pitch_x <<< 1) - roll_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_mix <= n_s1_mix;
        r_s1_lim <= r_fin_limit;
    end

    // stage 2: sign and magnitude
    logic                  r_s2_vld;
    logic [MAG_W-1:0]      r_s2_mag [LANES];
    logic [LANES-1:0]      r_s2_neg;
    logic [LIM_W-1:0]      r_s2_lim;
    logic [MAG_W-1:0]      n_s2_mag [LANES];
    logic [LANES-1:0]      n_s2_neg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s2_neg[l] = r_s1_mix[l][MIX_W-1];
            n_s2_mag[l] = n_s2_neg[l] ? MAG_W'(-r_s1_mix[l]) : MAG_W'(r_s1_mix[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_mag <= n_s2_mag;
        r_s2_neg <= n_s2_neg;
        r_s2_lim <= r_s1_lim;
    end

    // stage 3: largest magnitude and scale decision
    logic             r_s3_vld;
    logic [MAG_W-1:0] r_s3_mag [LANES];
    logic [LANES-1:0] r_s3_neg;
    logic [LIM_W-1:0] r_s3_lim;
    logic [MAG_W-1:0] r_s3_max;
    logic             r_s3_scaled;
    logic [MAG_W-1:0] max_a;
    logic [MAG_W-1:0] max_b;
    logic [MAG_W-1:0] n_s3_max;
    logic             n_s3_scaled;

    always_comb begin
        max_a       = (r_s2_mag[0] > r_s2_mag[1]) ? r_s2_mag[0] : r_s2_mag[1];
        max_b       = (r_s2_mag[2] > r_s2_mag[3]) ? r_s2_mag[2] : r_s2_mag[3];
        n_s3_max    = (max_a > max_b) ? max_a : max_b;
        // max above four times the limit (in quarter lsb) implies max nonzero
        n_s3_scaled = n_s3_max > {r_s2_lim, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_mag    <= r_s2_mag;
        r_s3_neg    <= r_s2_neg;
        r_s3_lim    <= r_s2_lim;
        r_s3_max    <= n_s3_max;
        r_s3_scaled <= n_s3_scaled;
    end

    // stage 4: products, start of divider
    logic                         r_dv   [DIV_STEPS+1];
    logic [LANES-1:0][REM_W-1:0]  r_rem  [DIV_STEPS+1];
    logic [LANES-1:0][QUOT_W-1:0] r_quot [DIV_STEPS+1];
    logic [MAG_W-1:0]             r_dsr  [DIV_STEPS+1];
    t_div_side                    r_side [DIV_STEPS+1];
    logic [LANES-1:0][REM_W-1:0]  n_prod;
    t_div_side                    n_side;

    always_comb begin
        n_side.neg    = r_s3_neg;
        n_side.scaled = r_s3_scaled;
        n_side.lim    = r_s3_lim;
        for (int l = 0; l < LANES; l++) begin
            n_prod[l]         = REM_W'(r_s3_mag[l]) * REM_W'(r_s3_lim);
            n_side.quarter[l] = r_s3_mag[l][MAG_W-1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_s3_vld;
        end
        r_rem[0]  <= n_prod;
        r_quot[0] <= '0;
        r_dsr[0]  <= r_s3_max;
        r_side[0] <= n_side;
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int SHIFT = DIV_STEPS - 1 - s;

        logic [REM_W-1:0]             dsr_sh;
        logic [LANES-1:0]             ge;
        logic [LANES-1:0][REM_W-1:0]  n_rem;
        logic [LANES-1:0][QUOT_W-1:0] n_quot;

        always_comb begin
            dsr_sh = REM_W'(r_dsr[s]) << SHIFT;
            for (int l = 0; l < LANES; l++) begin
                ge[l]     = r_rem[s][l] >= dsr_sh;
                n_rem[l]  = ge[l] ? (r_rem[s][l] - dsr_sh) : r_rem[s][l];
                n_quot[l] = {r_quot[s][l][QUOT_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else begin
                r_dv[s+1] <= r_dv[s];
            end
            r_rem[s+1]  <= n_rem;
            r_quot[s+1] <= n_quot;
            r_dsr[s+1]  <= r_dsr[s];
            r_side[s+1] <= r_side[s];
        end
    end

    // output stage: pick scaled or quarter value, clamp, restore sign
    logic [LANES-1:0][CMD_W-1:0]  fin_val;
    logic [LANES-1:0][QUOT_W-1:0] fin_mag;
    t_fin_word                    n_fin;
    t_fin_word                    r_fin;
    logic                         r_out_vld;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            fin_mag[l] = r_side[DIV_STEPS].scaled ? r_quot[DIV_STEPS][l]
                                                  : r_side[DIV_STEPS].quarter[l];
            if (fin_mag[l] > r_side[DIV_STEPS].lim) begin
                fin_mag[l] = r_side[DIV_STEPS].lim;
            end
            fin_val[l] = r_side[DIV_STEPS].neg[l] ? -CMD_W'(fin_mag[l])
                                                  : CMD_W'(fin_mag[l]);
        end
        n_fin.fin_one    = fin_val[0];
        n_fin.fin_two    = fin_val[1];
        n_fin.fin_three  = fin_val[2];
        n_fin.fin_four   = fin_val[3];
        n_fin.was_scaled = r_side[DIV_STEPS].scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dv[DIV_STEPS];
        end
        r_fin <= n_fin;
    end

    assign o_valid = r_out_vld;
    assign o_fin   = r_fin;

endmodule

`default_nettype wire

/* hdl/fmd_chk.sv */
`default_nettype none

module fmd_chk
    import fmd_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire t_cmd_word        i_cmd,
    input wire logic             i_cfg_we,
    input wire logic [LIM_W-1:0] i_cfg_wdata,
    input wire logic             o_valid,
    input wire t_fin_word        o_fin
);

    // shadow of the limit register as seen on the config port
    logic [LIM_W-1:0] r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    logic signed [CMD_W-1:0] lim_pos;
    logic signed [CMD_W-1:0] lim_neg;

    assign lim_pos = CMD_W'(r_lim);
    assign lim_neg = -CMD_W'(r_lim);

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("accepted word did not come out on time");

    // no result without a word accepted the latency earlier
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result word without matching command");

    // every fin stays within the configured limit
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fin.fin_one <= lim_pos && o_fin.fin_one >= lim_neg &&
                     o_fin.fin_two <= lim_pos && o_fin.fin_two >= lim_neg &&
                     o_fin.fin_three <= lim_pos && o_fin.fin_three >= lim_neg &&
                     o_fin.fin_four <= lim_pos && o_fin.fin_four >= lim_neg))
        else $error("fin deflection beyond limit");

    // an all-zero command gives all-zero fins without scaling
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == '0) |-> ##PIPE_LAT (o_fin == '0))
        else $error("zero command gave nonzero result");

endmodule

bind fin_mixer_desaturate fmd_chk u_fmd_chk (.*);

`default_nettype wire

/* verif/tb_fin_mixer_desaturate.sv */
`timescale 1ns / 100ps

module tb_fin_mixer_desaturate;
    import fmd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_cmd_word        i_cmd;
    logic             i_cfg_we;
    logic [LIM_W-1:0] i_cfg_wdata;
    logic             o_valid;
    t_fin_word        o_fin;

    t_fin_word        pending_fins[$];
    logic [LIM_W-1:0] fin_limit_model;
    int               sender_idle_pct;
    int               mismatch_cnt;
    int               cycle_cnt;
    logic             rst_done;

    fin_mixer_desaturate i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_fin       (o_fin)
    );

    always #2 i_clk = ~i_clk;

    // exact quarter-lsb mix, uniform scaling past the limit, then clamp
    function automatic t_fin_word mix_fins(t_cmd_word c, logic [LIM_W-1:0] lim);
        longint    roll, pitch, yaw, l, m, f;
        longint    q[4];
        logic      [CMD_W-1:0] fin[4];
        logic      scaled;
        t_fin_word r;
        roll  = longint'($signed(c.roll_cmd));
        pitch = longint'($signed(c.pitch_cmd));
        yaw   = longint'($signed(c.yaw_cmd));
        l     = longint'(lim);
        q[0]  =  2 * yaw - roll;
        q[1]  = -2 * pitch - roll;
        q[2]  = -2 * yaw - roll;
        q[3]  =  2 * pitch - roll;
        m = 0;
        for (int i = 0; i < 4; i++) begin
            if ((q[i] < 0 ? -q[i] : q[i]) > m) begin
                m = q[i] < 0 ? -q[i] : q[i];
            end
        end
        scaled = (m > 4 * l) && (m > 0);
        for (int i = 0; i < 4; i++) begin
            // signed division truncates toward zero
            f = scaled ? (q[i] * l) / m : q[i] / 4;
            if (f > l) f = l;
            if (f < -l) f = -l;
            fin[i] = CMD_W'(f);
        end
        r.fin_one    = fin[0];
        r.fin_two    = fin[1];
        r.fin_three  = fin[2];
        r.fin_four   = fin[3];
        r.was_scaled = scaled;
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] rand_field();
        logic [CMD_W-1:0] v;
        case ($urandom_range(3))
            0, 1: v = CMD_W'($urandom);
            2: v = CMD_W'($urandom_range(8191)) - CMD_W'(4096);
            default: begin
                case ($urandom_range(4))
                    0: v = 16'h8000;
                    1: v = 16'h7fff;
                    2: v = 16'h0000;
                    3: v = 16'hffff;
                    default: v = 16'h0001;
                endcase
            end
        endcase
        return v;
    endfunction

    // one command word; start is left high after acceptance so that
    // back-to-back words need no extra assignment in the same step
    task automatic send_cmd(input logic [CMD_W-1:0] roll, input logic [CMD_W-1:0] pitch,
                            input logic [CMD_W-1:0] yaw);
        t_cmd_word w;
        w.roll_cmd  = roll;
        w.pitch_cmd = pitch;
        w.yaw_cmd   = yaw;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_fins.push_back(mix_fins(w, fin_limit_model));
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_fins.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIM_W-1:0] v);
        wait_for_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        fin_limit_model = v;
    endtask

    task automatic test_reset_limit();
        sender_idle_pct = 0;
        send_cmd(16'h0000, 16'h0000, 16'h0000);
        send_cmd(16'h0100, 16'h0080, 16'hff40);  // well inside the limit
        send_cmd(16'hfffd, 16'h0003, 16'h0001);  // quarter truncation toward zero
        send_cmd(16'h7fff, 16'h7fff, 16'h7fff);
        send_cmd(16'h8000, 16'h8000, 16'h8000);
        send_cmd(16'h7fff, 16'h0000, 16'h0000);
        send_cmd(16'h8000, 16'h0000, 16'h0000);
        send_cmd(16'h0000, 16'h7fff, 16'h0000);
        send_cmd(16'h0000, 16'h8000, 16'h0000);
        send_cmd(16'h0000, 16'h0000, 16'h7fff);
        send_cmd(16'h0000, 16'h0000, 16'h8000);
        send_cmd(16'h7fff, 16'h8000, 16'h7fff);  // mix magnitude 98303, one short of the largest
        send_cmd(16'h0b33, 16'h0000, 16'h0000);  // roll right at the limit
    endtask

    task automatic test_zero_limit();
        set_limit('0);
        send_cmd(16'h0000, 16'h0000, 16'h0000);  // zero mix is left unscaled
        send_cmd(16'h0001, 16'h0000, 16'h0000);
        send_cmd(16'h0000, 16'hffff, 16'h0000);
        send_cmd(16'h8000, 16'h7fff, 16'h8000);
    endtask

    task automatic test_limit_extremes();
        set_limit(15'h7fff);
        send_cmd(16'h7fff, 16'h8000, 16'h7fff);
        send_cmd(16'h8000, 16'h7fff, 16'h8000);
        send_cmd(16'h1234, 16'hedcb, 16'h0f0f);
        set_limit(15'd1);
        send_cmd(16'h0004, 16'h0000, 16'h0000);
        send_cmd(16'h0005, 16'hfffe, 16'h0003);
        send_cmd(16'hffff, 16'h0001, 16'hffff);
    endtask

    task automatic test_random_traffic();
        logic [LIM_W-1:0] lim;
        int               idle_plan[3];
        idle_plan = '{20, 87, 0};
        for (int p = 0; p < 3; p++) begin
            sender_idle_pct = idle_plan[p];
            for (int n = 0; n < 265; n++) begin
                if (n % 90 == 0) begin
                    case ($urandom_range(5))
                        0: lim = '0;
                        1: lim = 15'h7fff;
                        2: lim = LIM_W'($urandom_range(32767));
                        3: lim = LIM_W'($urandom_range(64));
                        default: lim = LIM_W'($urandom_range(6000, 1000));
                    endcase
                    set_limit(lim);
                end else if (n == 45) begin
                    wait_for_idle();
                end
                send_cmd(rand_field(), rand_field(), rand_field());
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_fin_word want;
        if (rst_done && o_valid === 1'b1) begin
            if (pending_fins.size() == 0) begin
                $error("result word with nothing expected: %h", o_fin);
                mismatch_cnt++;
            end else begin
                want = pending_fins.pop_front();
                if (o_fin.fin_one !== want.fin_one) begin
                    $error("fin_one: expected %0d, got %0d", want.fin_one, o_fin.fin_one);
                    mismatch_cnt++;
                end
                if (o_fin.fin_two !== want.fin_two) begin
                    $error("fin_two: expected %0d, got %0d", want.fin_two, o_fin.fin_two);
                    mismatch_cnt++;
                end
                if (o_fin.fin_three !== want.fin_three) begin
                    $error("fin_three: expected %0d, got %0d", want.fin_three,
                           o_fin.fin_three);
                    mismatch_cnt++;
                end
                if (o_fin.fin_four !== want.fin_four) begin
                    $error("fin_four: expected %0d, got %0d", want.fin_four, o_fin.fin_four);
                    mismatch_cnt++;
                end
                if (o_fin.was_scaled !== want.was_scaled) begin
                    $error("was_scaled: expected %0b, got %0b", want.was_scaled,
                           o_fin.was_scaled);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_fin_mixer_desaturate: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        rst_done        = 1'b0;
        mismatch_cnt    = 0;
        cycle_cnt       = 0;
        sender_idle_pct = 0;
        fin_limit_model = LIMIT_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        test_reset_limit();
        test_zero_limit();
        test_limit_extremes();
        test_random_traffic();

        wait_for_idle();
        // catch any stray word after the last expected one
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb_fin_mixer_desaturate: clean");
        end else begin
            $display("tb_fin_mixer_desaturate: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/fmd_pkg.sv
hdl/fin_mixer_desaturate.sv
hdl/fmd_chk.sv
verif/tb_fin_mixer_desaturate.sv
